/* rtl/core/pli_pkg.sv */
package pli_pkg;

  // fixed field widths
  localparam int PC_W   = 9;
  localparam int SEG_W  = 8;
  localparam int DATA_W = 32;
  localparam int PROD_W = 64;
  // quotient bits kept; anything at or above 2**QUO_W saturates
  localparam int QUO_W  = 35;

  // request operations
  localparam logic [1:0] OP_WRITE   = 2'd0;
  localparam logic [1:0] OP_QUERY   = 2'd1;
  localparam logic [1:0] OP_RESTART = 2'd2;
  localparam logic [1:0] OP_NOP     = 2'd3;

  // result status codes
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_BELOW = 2'd1;
  localparam logic [1:0] STAT_ABOVE = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHK_LO,
    S_CHK_HI,
    S_WALK,
    S_RD_Y0,
    S_RD_Y1,
    S_MUL,
    S_DIV_GO,
    S_DIV_WAIT,
    S_FIN
  } pli_state_t;

  typedef struct packed {
    logic done;
    logic ovf;
  } div_status_t;

endpackage

/* rtl/core/pli_ram.sv */
module pli_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/core/pli_div.sv */
module pli_div
  import pli_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [PROD_W-1:0] dividend,
  input  logic [DATA_W-1:0] divisor,
  output div_status_t       status,
  output logic [QUO_W-1:0]  quotient
);

  localparam int CNT_W = $clog2(QUO_W + 1);
  localparam int HI_W  = PROD_W - QUO_W;

  logic              busy;
  logic              done;
  logic              ovf;
  logic [CNT_W-1:0]  cnt;
  logic [DATA_W-1:0] rem;
  logic [DATA_W-1:0] dvs;
  logic [QUO_W-1:0]  sh;

  logic [HI_W-1:0]   hi;
  logic              too_big;
  logic [DATA_W:0]   trial;
  logic [DATA_W:0]   diff;
  logic              fits;

  // upper dividend bits decide saturation before any iteration
  assign hi      = dividend[PROD_W-1:QUO_W];
  assign too_big = DATA_W'(hi) >= divisor;

  // one restoring step per cycle
  assign trial = {rem, sh[QUO_W-1]};
  assign diff  = trial - {1'b0, dvs};
  assign fits  = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      ovf  <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        ovf <= too_big;
        rem <= DATA_W'(hi);
        sh  <= dividend[QUO_W-1:0];
        dvs <= divisor;
        cnt <= CNT_W'(QUO_W);
        if (too_big) begin
          done <= 1'b1;
        end else begin
          busy <= 1'b1;
        end
      end else if (busy) begin
        rem <= fits ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
        sh  <= {sh[QUO_W-2:0], fits};
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign status.done = done;
  assign status.ovf  = ovf;
  assign quotient    = sh;

endmodule

/* rtl/core/piecewise_linear_interpolator.sv */
// Piecewise linear interpolator over up to MAX_POINTS breakpoints (x, y) in signed Q16.16,
// held in two single-port-read memories. A write request (op 0) stores one breakpoint and
// passes straight to the output register, as does a no-op request. A query walks forward
// from the kept segment one breakpoint per cycle, then forms y0 + trunc(dy*(xq-x0)/dx) with
// a registered 32x32 multiply and a one-bit-per-cycle restoring divider of 35 steps. A
// zero-width segment skips the divider, a quotient that must saturate ends the division at
// once, and an out-of-range query stops after the range checks. Results are saturated to
// 32 bits. A new request is taken while the previous result still waits in the output
// register. The user must write point_count only while the block is idle; the block itself
// does not enforce this; breakpoints read by a query must have been written beforehand.
module piecewise_linear_interpolator
  import pli_pkg::*;
#(
  parameter int MAX_POINTS = 256
) (
  input  logic                     clk,
  input  logic                     rst,
  // configuration
  input  logic                     cfg_write,
  input  logic [PC_W-1:0]          cfg_data,
  // request channel
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [1:0]               op,
  input  logic [SEG_W-1:0]         point_index,
  input  logic signed [DATA_W-1:0] x_value,
  input  logic signed [DATA_W-1:0] y_value,
  // result channel
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [DATA_W-1:0] interpolated,
  output logic [1:0]               status,
  output logic [SEG_W-1:0]         segment
);

  localparam int AW    = $clog2(MAX_POINTS);
  localparam int RES_W = DATA_W + 5;

  function automatic logic [DATA_W-1:0] mag(input logic signed [DATA_W:0] d);
    logic signed [DATA_W:0] n;
    n = -d;
    return d[DATA_W] ? n[DATA_W-1:0] : d[DATA_W-1:0];
  endfunction

  pli_state_t state, state_next;

  // control and datapath registers
  logic [PC_W-1:0]          point_count;
  logic [SEG_W-1:0]         search_segment;
  logic [1:0]               op_q;
  logic signed [DATA_W-1:0] xq;
  logic [PC_W-1:0]          c_m2;
  logic [PC_W-1:0]          last;
  logic [PC_W-1:0]          idx;
  logic [DATA_W-1:0]        xi;
  logic [DATA_W-1:0]        x1;
  logic [DATA_W-1:0]        y0;
  logic [1:0]               res_status;
  logic [DATA_W-1:0]        result;
  logic                     neg;
  logic                     dx_zero;
  logic [DATA_W-1:0]        mdy;
  logic [DATA_W-1:0]        mdxq;
  logic [DATA_W-1:0]        mdx;
  logic [PROD_W-1:0]        prod;

  // combinational
  logic                     accept;
  logic                     out_free;
  logic                     out_load;
  logic                     div_start;
  logic                     wr_en;
  logic [PC_W-1:0]          pc_lo;
  logic [PC_W-1:0]          c_in;
  logic [PC_W-1:0]          cm2_in;
  logic [PC_W-1:0]          seg_in;
  logic [PC_W-1:0]          start_idx;
  logic [PC_W-1:0]          idx_p1;
  logic [PC_W-1:0]          idx_p2;
  logic [PC_W-1:0]          xa_sel;
  logic [PC_W-1:0]          ya_sel;
  logic [DATA_W-1:0]        x_rd;
  logic [DATA_W-1:0]        y_rd;
  logic                     lo_miss;
  logic                     hi_miss;
  logic                     advance;
  logic                     is_query;
  logic                     query_ok;
  logic signed [DATA_W:0]   dy;
  logic signed [DATA_W:0]   dxq;
  logic signed [DATA_W:0]   dx;
  div_status_t              div_st;
  logic [QUO_W-1:0]         quotient;
  logic                     sat;
  logic signed [RES_W-1:0]  ys;
  logic signed [RES_W-1:0]  qs;
  logic signed [RES_W-1:0]  sum;
  logic [DATA_W-1:0]        lerp_val;

  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;
  assign wr_en    = accept && (op == OP_WRITE) && (32'(point_index) < MAX_POINTS);

  // breakpoints in use and starting segment for a new request
  assign pc_lo     = (point_count < PC_W'(2)) ? PC_W'(2) : point_count;
  assign c_in      = (32'(pc_lo) > MAX_POINTS) ? PC_W'(MAX_POINTS) : pc_lo;
  assign cm2_in    = c_in - PC_W'(2);
  assign seg_in    = (op == OP_RESTART) ? '0 : PC_W'(search_segment);
  assign start_idx = (seg_in > cm2_in) ? cm2_in : seg_in;

  assign idx_p1 = idx + PC_W'(1);
  assign idx_p2 = idx + PC_W'(2);

  // segment checks on the word just read
  assign lo_miss = $signed(x_rd) > xq;
  assign hi_miss = $signed(x_rd) < xq;
  assign advance = ($signed(x_rd) <= xq) && (idx < c_m2);

  assign is_query = (op_q == OP_QUERY) || (op_q == OP_RESTART);
  assign query_ok = is_query && (res_status == STAT_OK);

  // breakpoint memories
  pli_ram #(.WIDTH(DATA_W), .DEPTH(MAX_POINTS)) u_x_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (AW'(point_index)),
    .wdata (x_value),
    .raddr (AW'(xa_sel)),
    .rdata (x_rd)
  );

  pli_ram #(.WIDTH(DATA_W), .DEPTH(MAX_POINTS)) u_y_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (AW'(point_index)),
    .wdata (y_value),
    .raddr (AW'(ya_sel)),
    .rdata (y_rd)
  );

  pli_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (prod),
    .divisor  (mdx),
    .status   (div_st),
    .quotient (quotient)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          case (op)
            OP_QUERY, OP_RESTART: state_next = S_CHK_LO;
            OP_WRITE, OP_NOP:     state_next = S_FIN;
            default:              state_next = S_FIN;
          endcase
        end
      end
      S_CHK_LO:   state_next = lo_miss ? S_FIN : S_CHK_HI;
      S_CHK_HI:   state_next = hi_miss ? S_FIN : S_WALK;
      S_WALK:     state_next = advance ? S_WALK : S_RD_Y0;
      S_RD_Y0:    state_next = S_RD_Y1;
      S_RD_Y1:    state_next = S_MUL;
      S_MUL:      state_next = dx_zero ? S_FIN : S_DIV_GO;
      S_DIV_GO:   state_next = S_DIV_WAIT;
      S_DIV_WAIT: state_next = div_st.done ? S_FIN : S_DIV_WAIT;
      S_FIN:      state_next = out_free ? S_IDLE : S_FIN;
      default:    state_next = S_IDLE;
    endcase
  end

  // state outputs and read addresses
  always_comb begin
    in_ready  = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    xa_sel    = idx;
    ya_sel    = idx;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        xa_sel   = start_idx;
      end
      S_CHK_LO: xa_sel = last;
      S_CHK_HI: xa_sel = idx_p1;
      S_WALK:   xa_sel = idx_p2;
      S_RD_Y0:  ya_sel = idx_p1;
      S_DIV_GO: div_start = 1'b1;
      S_FIN:    out_load = out_free;
      default: begin
        xa_sel = idx;
      end
    endcase
  end

  // differences and magnitudes for the slope
  assign dy  = $signed({y_rd[DATA_W-1], y_rd}) - $signed({y0[DATA_W-1], y0});
  assign dxq = $signed({xq[DATA_W-1], xq}) - $signed({xi[DATA_W-1], xi});
  assign dx  = $signed({x1[DATA_W-1], x1}) - $signed({xi[DATA_W-1], xi});

  // sum with saturation
  assign sat = div_st.ovf || (quotient[QUO_W-1] && (|quotient[QUO_W-2:0]));
  assign ys  = RES_W'($signed(y0));
  assign qs  = $signed(RES_W'(quotient));
  assign sum = neg ? (ys - qs) : (ys + qs);

  always_comb begin
    if (sat) begin
      lerp_val = neg ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
    end else if (!sum[RES_W-1] && (|sum[RES_W-2:DATA_W-1])) begin
      lerp_val = {1'b0, {(DATA_W-1){1'b1}}};
    end else if (sum[RES_W-1] && !(&sum[RES_W-2:DATA_W-1])) begin
      lerp_val = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      lerp_val = sum[DATA_W-1:0];
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      point_count    <= PC_W'(2);
      search_segment <= '0;
      out_valid      <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_write) begin
        point_count <= cfg_data;
      end
      if (accept && (op == OP_RESTART)) begin
        search_segment <= '0;
      end else if (out_load && query_ok) begin
        search_segment <= idx[SEG_W-1:0];
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        op_q       <= op;
        xq         <= x_value;
        c_m2       <= cm2_in;
        last       <= c_in - PC_W'(1);
        idx        <= start_idx;
        res_status <= STAT_OK;
        result     <= '0;
      end
      S_CHK_LO: begin
        xi <= x_rd;
        if (lo_miss) begin
          res_status <= STAT_BELOW;
        end
      end
      S_CHK_HI: begin
        if (hi_miss) begin
          res_status <= STAT_ABOVE;
        end
      end
      S_WALK: begin
        if (advance) begin
          idx <= idx_p1;
          xi  <= x_rd;
        end else begin
          x1 <= x_rd;
        end
      end
      S_RD_Y0: y0 <= y_rd;
      S_RD_Y1: begin
        mdy     <= mag(dy);
        mdxq    <= mag(dxq);
        mdx     <= mag(dx);
        neg     <= dy[DATA_W] ^ dxq[DATA_W] ^ dx[DATA_W];
        dx_zero <= (dx == '0);
      end
      S_MUL: begin
        prod <= PROD_W'(mdy) * PROD_W'(mdxq);
        if (dx_zero) begin
          result <= y0;
        end
      end
      S_DIV_WAIT: begin
        if (div_st.done) begin
          result <= lerp_val;
        end
      end
      default: begin
        result <= result;
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (out_load) begin
      interpolated <= result;
      status       <= res_status;
      segment      <= query_ok ? idx[SEG_W-1:0] : search_segment;
    end
  end

endmodule
